### src/lci_pkg.sv
// Shared number format, types and helpers for the linear constraint interval unit.
package lci_pkg;

    // Fixed-point format of every value: signed, VALUE_WIDTH bits, FRACTION_BITS fraction bits.
    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic        [VALUE_WIDTH-1:0] mag_t;

    // Range limits of the format and the magnitude of its most negative value.
    localparam value_t VMAX     = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VMIN     = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam mag_t   MAG_HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam mag_t   MAG_MAX  = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // The value 1.0, clipped to the format when it cannot be represented.
    localparam value_t ONE_Q = (FRACTION_BITS >= VALUE_WIDTH - 1) ? VMAX :
                               value_t'(64'd1 << FRACTION_BITS);

    // Magnitude of a two's complement value; the most negative value maps to MAG_HALF.
    function automatic mag_t abs_mag(input value_t v);
        abs_mag = v[VALUE_WIDTH-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
    endfunction

endpackage

### src/linear_constraint_interval_unit.sv
// Linear constraint interval unit: row sequencer, shared radix-2 divider and running interval.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-------------------------------------------------
//  s_      | in        | s_valid / s_ready  | coef_u, coef_x, offset, x_value, query_u, last_row
//  m_      | out       | m_valid / m_ready  | lower/upper bound, unbounded flags, empty, saturated
//
//  A row that bounds the interval, in x mode or in u mode, runs through the 32 steps of the
//  shared radix-2 divider before the next row is accepted; a quotient too large for the format
//  skips those steps. A skipped or degenerate row, or any row after the interval went empty,
//  bypasses the divider. A last row also passes the finish step, which loads the result
//  register and waits there while that register is full.
//  Reset is synchronous and active low; it opens both bounds and clears the flags.
//  A stalled result does not block the input side until the next last row must be emitted.
module linear_constraint_interval_unit
    import lci_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input rows
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [31:0]        s_coef_u,
    input  logic signed [31:0]        s_coef_x,
    input  logic signed [31:0]        s_offset,
    input  logic signed [31:0]        s_x_value,
    input  logic                      s_query_u,
    input  logic                      s_last_row,
    // Result intervals
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_lower_bound,
    output logic signed [31:0]        m_upper_bound,
    output logic                      m_lower_unbounded,
    output logic                      m_upper_unbounded,
    output logic                      m_interval_empty,
    output logic                      m_saturated
);

    localparam int W     = VALUE_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int PW    = 2 * W - F;
    localparam int CNT_W = $clog2(W + 1);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_PSAT   = 4'd3;
    localparam logic [3:0] ST_RHS    = 4'd4;
    localparam logic [3:0] ST_SEL    = 4'd5;
    localparam logic [3:0] ST_DIVCHK = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_QSAT   = 4'd8;
    localparam logic [3:0] ST_APPLY  = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    localparam logic [PW-1:0] P_HALF = {{(PW-W){1'b0}}, MAG_HALF};
    localparam logic [PW-1:0] P_MAX  = {{(PW-W){1'b0}}, MAG_MAX};

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic             lower_open_reg, lower_open_next;
    logic             upper_open_reg, upper_open_next;
    logic             empty_seen_reg, empty_seen_next;
    logic             clip_seen_reg, clip_seen_next;
    logic             m_valid_reg, m_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Datapath registers.
    value_t           a_reg, a_next, b_reg, b_next, c_reg, c_next, x_reg, x_next;
    logic             umode_reg, umode_next, last_reg, last_next;
    logic [2*W-1:0]   prod_reg, prod_next;
    value_t           p_reg, p_next, rhs_reg, rhs_next;
    mag_t             num_reg, num_next, den_reg, den_next;
    logic             qsign_reg, qsign_next, to_upper_reg, to_upper_next, ovf_reg, ovf_next;
    mag_t             rem_reg, rem_next, shift_reg, shift_next, quo_reg, quo_next;
    value_t           val_reg, val_next;
    value_t           run_lower_reg, run_lower_next, run_upper_reg, run_upper_next;
    value_t           m_lower_reg, m_lower_next, m_upper_reg, m_upper_next;
    logic             m_lunb_reg, m_lunb_next, m_uunb_reg, m_uunb_next;
    logic             m_empty_reg, m_empty_next, m_sat_reg, m_sat_next;

    // Combinational helpers.
    logic [3:0]       done_state;
    logic [PW-1:0]    pmag;
    logic             pneg;
    logic signed [W+1:0] rsum;
    logic [W:0]       rem_shift;
    logic [W:0]       rem_diff;
    logic             qneg;

    assign done_state = last_reg ? ST_FINISH : ST_IDLE;
    assign pmag       = prod_reg[2*W-1:F];
    assign pneg       = (b_reg[W-1] ^ x_reg[W-1]) & (|pmag);
    assign rsum       = -$signed({{2{p_reg[W-1]}}, p_reg}) - $signed({{2{c_reg[W-1]}}, c_reg});
    assign rem_shift  = {rem_reg, shift_reg[W-1]};
    assign rem_diff   = rem_shift - {1'b0, den_reg};
    assign qneg       = qsign_reg & (|quo_reg);

    // Next-state logic of the sequencer and datapath.
    always_comb begin
        state_next      = state_reg;
        lower_open_next = lower_open_reg;
        upper_open_next = upper_open_reg;
        empty_seen_next = empty_seen_reg;
        clip_seen_next  = clip_seen_reg;
        m_valid_next    = m_valid_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        x_next          = x_reg;
        umode_next      = umode_reg;
        last_next       = last_reg;
        prod_next       = prod_reg;
        p_next          = p_reg;
        rhs_next        = rhs_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        qsign_next      = qsign_reg;
        to_upper_next   = to_upper_reg;
        ovf_next        = ovf_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        quo_next        = quo_reg;
        val_next        = val_reg;
        run_lower_next  = run_lower_reg;
        run_upper_next  = run_upper_reg;
        m_lower_next    = m_lower_reg;
        m_upper_next    = m_upper_reg;
        m_lunb_next     = m_lunb_reg;
        m_uunb_next     = m_uunb_reg;
        m_empty_next    = m_empty_reg;
        m_sat_next      = m_sat_reg;

        // The result register empties when its transaction completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next     = value_t'(s_coef_u);
                    b_next     = value_t'(s_coef_x);
                    c_next     = value_t'(s_offset);
                    x_next     = value_t'(s_x_value);
                    umode_next = s_query_u;
                    last_next  = s_last_row;
                    state_next = ST_DECODE;
                end
            end

            // Route the row: skip it, mark the interval empty, start the u-mode product, or set up the division.
            ST_DECODE: begin
                if (empty_seen_reg) begin
                    state_next = done_state;
                end else if (umode_reg) begin
                    state_next = ST_MUL;
                end else if (a_reg != '0) begin
                    state_next = done_state;
                end else if (b_reg == '0) begin
                    if (!c_reg[W-1] && (c_reg != '0)) begin
                        empty_seen_next = 1'b1;
                    end
                    state_next = done_state;
                end else begin
                    num_next      = abs_mag(c_reg);
                    den_next      = abs_mag(b_reg);
                    qsign_next    = ~c_reg[W-1] ^ b_reg[W-1];
                    to_upper_next = ~b_reg[W-1];
                    state_next    = ST_DIVCHK;
                end
            end

            // Magnitude product of coef_x and x_value.
            ST_MUL: begin
                prod_next  = abs_mag(b_reg) * abs_mag(x_reg);
                state_next = ST_PSAT;
            end

            // Truncate the product to the format and clip it.
            ST_PSAT: begin
                if (pneg) begin
                    if (pmag > P_HALF) begin
                        p_next         = VMIN;
                        clip_seen_next = 1'b1;
                    end else begin
                        p_next = value_t'(~pmag[W-1:0] + 1'b1);
                    end
                end else if (pmag > P_MAX) begin
                    p_next         = VMAX;
                    clip_seen_next = 1'b1;
                end else begin
                    p_next = value_t'(pmag[W-1:0]);
                end
                state_next = ST_RHS;
            end

            // Right-hand side -b*x - c, clipped to the format.
            ST_RHS: begin
                if ((rsum[W+1:W-1] != '0) && (rsum[W+1:W-1] != '1)) begin
                    rhs_next       = rsum[W+1] ? VMIN : VMAX;
                    clip_seen_next = 1'b1;
                end else begin
                    rhs_next = value_t'(rsum[W-1:0]);
                end
                state_next = ST_SEL;
            end

            // Zero coef_u: a negative right-hand side empties the interval. Else set up the division.
            ST_SEL: begin
                if (a_reg == '0) begin
                    if (rhs_reg[W-1]) begin
                        empty_seen_next = 1'b1;
                    end
                    state_next = done_state;
                end else begin
                    num_next      = abs_mag(rhs_reg);
                    den_next      = abs_mag(a_reg);
                    qsign_next    = rhs_reg[W-1] ^ a_reg[W-1];
                    to_upper_next = ~a_reg[W-1];
                    state_next    = ST_DIVCHK;
                end
            end

            // Quotients of 2^W or more clip; otherwise the quotient fits in W bits.
            ST_DIVCHK: begin
                ovf_next   = {{(W-F){1'b0}}, num_reg} >= {den_reg, {(W-F){1'b0}}};
                rem_next   = mag_t'(num_reg >> (W - F));
                shift_next = {num_reg[W-F-1:0], {F{1'b0}}};
                quo_next   = '0;
                cnt_next   = CNT_W'(W);
                state_next = ovf_next ? ST_QSAT : ST_DIV;
            end

            // One restoring division step per cycle on the shared subtractor.
            ST_DIV: begin
                if (!rem_diff[W]) begin
                    rem_next = rem_diff[W-1:0];
                end else begin
                    rem_next = rem_shift[W-1:0];
                end
                quo_next   = {quo_reg[W-2:0], ~rem_diff[W]};
                shift_next = {shift_reg[W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_QSAT;
                end
            end

            // Apply the quotient sign and clip to the format.
            ST_QSAT: begin
                if (ovf_reg) begin
                    val_next       = qsign_reg ? VMIN : VMAX;
                    clip_seen_next = 1'b1;
                end else if (qneg) begin
                    if (quo_reg > MAG_HALF) begin
                        val_next       = VMIN;
                        clip_seen_next = 1'b1;
                    end else begin
                        val_next = value_t'(~quo_reg + 1'b1);
                    end
                end else if (quo_reg > MAG_MAX) begin
                    val_next       = VMAX;
                    clip_seen_next = 1'b1;
                end else begin
                    val_next = value_t'(quo_reg);
                end
                state_next = ST_APPLY;
            end

            // Tighten the chosen side of the running interval.
            ST_APPLY: begin
                if (to_upper_reg) begin
                    if (upper_open_reg || (val_reg < run_upper_reg)) begin
                        run_upper_next = val_reg;
                    end
                    upper_open_next = 1'b0;
                end else begin
                    if (lower_open_reg || (val_reg > run_lower_reg)) begin
                        run_lower_next = val_reg;
                    end
                    lower_open_next = 1'b0;
                end
                state_next = done_state;
            end

            // Load the result register once it is free, then start a new interval.
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (empty_seen_reg) begin
                        m_lower_next = ONE_Q;
                        m_upper_next = '0;
                        m_lunb_next  = 1'b0;
                        m_uunb_next  = 1'b0;
                        m_empty_next = 1'b1;
                    end else begin
                        m_lower_next = lower_open_reg ? value_t'(0) : run_lower_reg;
                        m_upper_next = upper_open_reg ? value_t'(0) : run_upper_reg;
                        m_lunb_next  = lower_open_reg;
                        m_uunb_next  = upper_open_reg;
                        m_empty_next = 1'b0;
                    end
                    m_sat_next      = clip_seen_reg;
                    lower_open_next = 1'b1;
                    upper_open_next = 1'b1;
                    empty_seen_next = 1'b0;
                    clip_seen_next  = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lower_open_reg <= 1'b1;
            upper_open_reg <= 1'b1;
            empty_seen_reg <= 1'b0;
            clip_seen_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            lower_open_reg <= lower_open_next;
            upper_open_reg <= upper_open_next;
            empty_seen_reg <= empty_seen_next;
            clip_seen_reg  <= clip_seen_next;
            m_valid_reg    <= m_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        x_reg         <= x_next;
        umode_reg     <= umode_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        p_reg         <= p_next;
        rhs_reg       <= rhs_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        qsign_reg     <= qsign_next;
        to_upper_reg  <= to_upper_next;
        ovf_reg       <= ovf_next;
        rem_reg       <= rem_next;
        shift_reg     <= shift_next;
        quo_reg       <= quo_next;
        val_reg       <= val_next;
        run_lower_reg <= run_lower_next;
        run_upper_reg <= run_upper_next;
        m_lower_reg   <= m_lower_next;
        m_upper_reg   <= m_upper_next;
        m_lunb_reg    <= m_lunb_next;
        m_uunb_reg    <= m_uunb_next;
        m_empty_reg   <= m_empty_next;
        m_sat_reg     <= m_sat_next;
    end

    // Ports.
    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_lower_bound     = 32'(m_lower_reg);
    assign m_upper_bound     = 32'(m_upper_reg);
    assign m_lower_unbounded = m_lunb_reg;
    assign m_upper_unbounded = m_uunb_reg;
    assign m_interval_empty  = m_empty_reg;
    assign m_saturated       = m_sat_reg;

    // An empty interval is reported with closed sides and a zero upper end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_interval_empty |-> !m_lower_unbounded && !m_upper_unbounded &&
                                        (m_upper_bound == 32'sd0))
        else $error("empty interval reported with open side or nonzero upper end");

    // The divider never runs with an exhausted step count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg != '0)
        else $error("divider step count exhausted while dividing");

    // Emitting a result restarts the running interval.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && (!m_valid_reg || m_ready) |=>
            lower_open_reg && upper_open_reg && !empty_seen_reg && !clip_seen_reg && m_valid_reg)
        else $error("running interval not restarted after a result");

    // A result is only produced from the finish step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared outside the finish step");

endmodule
